@@ rtl/core/tsfb_pkg.sv @@
// ----------------------------------------------------------------------------
// tsfb_pkg
// shared types and constants of the tcp syn frame builder
// ----------------------------------------------------------------------------
package tsfb_pkg;

    // frame layout
    localparam int FRAME_WORDS = 37;
    localparam logic [5:0] LAST_INDEX = 6'd36;

    // register map, index = paddr[5:3]
    localparam logic [2:0] REG_SOURCE_MAC  = 3'd0;
    localparam logic [2:0] REG_DEST_MAC    = 3'd1;
    localparam logic [2:0] REG_IP_SRC_ADDR = 3'd2;
    localparam logic [2:0] REG_DEST_IP     = 3'd3;
    localparam logic [2:0] REG_SOURCE_PORT = 3'd4;
    localparam logic [2:0] REG_DEST_PORT   = 3'd5;
    localparam logic [2:0] REG_WINDOW_SIZE = 3'd6;
    localparam logic [2:0] REG_MAX_SEGMENT = 3'd7;

    // register reset values
    localparam logic [15:0] RST_SOURCE_PORT = 16'd54321;
    localparam logic [15:0] RST_DEST_PORT   = 16'd80;
    localparam logic [15:0] RST_WINDOW_SIZE = 16'd5480;
    localparam logic [15:0] RST_MAX_SEGMENT = 16'd1460;

    // fixed header words
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
    localparam logic [15:0] IP_TOTAL_LEN   = 16'd60;
    localparam logic [15:0] IP_IDENT       = 16'd1;
    localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
    localparam logic [15:0] IP_TTL_PROTO   = 16'h4006;
    localparam logic [15:0] PROTO_TCP      = 16'd6;
    localparam logic [15:0] TCP_LEN        = 16'd40;
    localparam logic [15:0] TCP_OFF_FLAGS  = 16'hA002;
    localparam logic [15:0] OPT_MSS_HDR    = 16'h0204;
    localparam logic [15:0] OPT_SACK_OK    = 16'h0402;
    localparam logic [15:0] OPT_TS_HDR     = 16'h080A;
    localparam logic [15:0] TS_VALUE_HI    = 16'h047C;
    localparam logic [15:0] TS_VALUE_LO    = 16'hCFF8;
    localparam logic [15:0] OPT_NOP_WS     = 16'h0103;
    localparam logic [15:0] OPT_WS_SHIFT   = 16'h0305;

    // constant parts of both checksums
    localparam logic [19:0] IP_CONST_SUM = 20'(IP_VER_IHL_TOS) + 20'(IP_TOTAL_LEN)
        + 20'(IP_IDENT) + 20'(IP_FLAGS_DF) + 20'(IP_TTL_PROTO);
    localparam logic [19:0] TCP_CONST_SUM = 20'(PROTO_TCP) + 20'(TCP_LEN)
        + 20'(TCP_OFF_FLAGS) + 20'(OPT_MSS_HDR) + 20'(OPT_SACK_OK) + 20'(OPT_TS_HDR)
        + 20'(TS_VALUE_HI) + 20'(TS_VALUE_LO) + 20'(OPT_NOP_WS) + 20'(OPT_WS_SHIFT);

    typedef struct packed {
        logic [47:0] source_mac;
        logic [47:0] dest_mac;
        logic [31:0] ip_src_addr;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] window_size;
        logic [15:0] max_segment;
    } cfg_t;

    // one queued request with the partial tcp sum of its seq and ack words
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] ack;
        logic [17:0] part_sum;
    } req_t;

endpackage

@@ rtl/core/tcp_syn_frame_builder_top.sv @@
// ----------------------------------------------------------------------------
// tcp_syn_frame_builder_top
// builds one ethernet/ipv4/tcp syn frame of 37 words for each request
// ----------------------------------------------------------------------------
// path: a request passes the queue, the frame state registers and the word output
//   register before its first word shows on m_axis; one frame word per cycle while
//   m_axis_tready holds, and frames follow back to back while the queue is not empty
// reset: rst_n clears queue, serializer and output valid; config registers
//   return to their defaults (macs and ips zero, port 54321 to 80, window 5480,
//   mss 1460)
// ----------------------------------------------------------------------------
module tcp_syn_frame_builder_top
    import tsfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,

    // register port, register i at byte address 8*i
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // sequence_number [31:0], ack_number [63:32]

    // frame word stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // frame_word [15:0], word_index [21:16], zero [23:22]
    output logic        m_axis_tlast   // last_word
);

    cfg_t     cfg_reg;
    logic     cfg_write;
    logic [2:0] reg_index;

    logic     queue_full;
    logic     push;
    req_t     push_req;
    logic     pop;
    logic     head_valid;
    req_t     head_req;

    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    // the write lands in the access phase
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_mac  <= '0;
            cfg_reg.dest_mac    <= '0;
            cfg_reg.ip_src_addr <= '0;
            cfg_reg.dest_ip     <= '0;
            cfg_reg.source_port <= RST_SOURCE_PORT;
            cfg_reg.dest_port   <= RST_DEST_PORT;
            cfg_reg.window_size <= RST_WINDOW_SIZE;
            cfg_reg.max_segment <= RST_MAX_SEGMENT;
        end
        else if (cfg_write)
        begin
            // only the low bits up to each register's width are kept
            case (reg_index)
                REG_SOURCE_MAC:  cfg_reg.source_mac  <= pwdata[47:0];
                REG_DEST_MAC:    cfg_reg.dest_mac    <= pwdata[47:0];
                REG_IP_SRC_ADDR: cfg_reg.ip_src_addr <= pwdata[31:0];
                REG_DEST_IP:     cfg_reg.dest_ip     <= pwdata[31:0];
                REG_SOURCE_PORT: cfg_reg.source_port <= pwdata[15:0];
                REG_DEST_PORT:   cfg_reg.dest_port   <= pwdata[15:0];
                REG_WINDOW_SIZE: cfg_reg.window_size <= pwdata[15:0];
                REG_MAX_SEGMENT: cfg_reg.max_segment <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // register readback, zero extended
    always_comb
    begin
        case (reg_index)
            REG_SOURCE_MAC:  prdata = 64'(cfg_reg.source_mac);
            REG_DEST_MAC:    prdata = 64'(cfg_reg.dest_mac);
            REG_IP_SRC_ADDR: prdata = 64'(cfg_reg.ip_src_addr);
            REG_DEST_IP:     prdata = 64'(cfg_reg.dest_ip);
            REG_SOURCE_PORT: prdata = 64'(cfg_reg.source_port);
            REG_DEST_PORT:   prdata = 64'(cfg_reg.dest_port);
            REG_WINDOW_SIZE: prdata = 64'(cfg_reg.window_size);
            REG_MAX_SEGMENT: prdata = 64'(cfg_reg.max_segment);
            default:         prdata = '0;
        endcase
    end

    // front: accepts a request and pre-adds its seq and ack words
    tsfb_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .queue_full    (queue_full),
        .push          (push),
        .push_req      (push_req)
    );

    // queue decouples request intake from frame output
    tsfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_req   (push_req),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    // back: completes both checksums and streams the frame words
    tsfb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head_valid    (head_valid),
        .head_req      (head_req),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ rtl/core/tsfb_front.sv @@
// ----------------------------------------------------------------------------
// tsfb_front
// takes requests and adds up their sequence and ack words for the tcp checksum
// ----------------------------------------------------------------------------
module tsfb_front
    import tsfb_pkg::*;
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // sequence_number [31:0], ack_number [63:32]
    input  logic        queue_full,
    output logic        push,
    output req_t        push_req
);

    logic [31:0] seq;
    logic [31:0] ack;

    assign seq = s_axis_tdata[31:0];
    assign ack = s_axis_tdata[63:32];

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    always_comb
    begin
        push_req.seq      = seq;
        push_req.ack      = ack;
        push_req.part_sum = 18'(seq[31:16]) + 18'(seq[15:0])
                          + 18'(ack[31:16]) + 18'(ack[15:0]);
    end

endmodule

@@ rtl/core/tsfb_queue.sv @@
// ----------------------------------------------------------------------------
// tsfb_queue
// short request queue between the front and the frame serializer
// ----------------------------------------------------------------------------
module tsfb_queue
    import tsfb_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_req,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output req_t head_req
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    req_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

@@ rtl/core/tsfb_back.sv @@
// ----------------------------------------------------------------------------
// tsfb_back
// finishes the checksums and sends the 37 frame words of each request
// ----------------------------------------------------------------------------
module tsfb_back
    import tsfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        head_valid,
    input  req_t        head_req,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // frame_word [15:0], word_index [21:16], zero [23:22]
    output logic        m_axis_tlast   // last_word
);

    // config-only sums, refreshed every cycle
    logic [19:0] ip_sum;
    logic [16:0] ip_fold1;
    logic [15:0] ip_fold2;
    logic [15:0] ip_csum_reg;
    logic [19:0] tcp_cfg_sum;
    logic [19:0] tcp_cfg_sum_reg;

    // per frame state
    logic        active_reg;
    logic        active_next;
    logic [5:0]  idx_reg;
    logic [5:0]  idx_next;
    logic [31:0] seq_reg;
    logic [31:0] ack_reg;
    logic [15:0] tcp_csum_reg;
    logic [20:0] tcp_sum;
    logic [16:0] tcp_fold1;
    logic [15:0] tcp_fold2;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_word_reg;
    logic [5:0]  out_index_reg;
    logic        out_last_reg;
    logic [15:0] word;

    logic advance;
    logic emit;
    logic load;

    always_comb
    begin
        ip_sum   = IP_CONST_SUM
                 + 20'(cfg.ip_src_addr[31:16]) + 20'(cfg.ip_src_addr[15:0])
                 + 20'(cfg.dest_ip[31:16]) + 20'(cfg.dest_ip[15:0]);
        ip_fold1 = 17'(ip_sum[15:0]) + 17'(ip_sum[19:16]);
        ip_fold2 = ip_fold1[15:0] + 16'(ip_fold1[16]);

        tcp_cfg_sum = TCP_CONST_SUM
                    + 20'(cfg.ip_src_addr[31:16]) + 20'(cfg.ip_src_addr[15:0])
                    + 20'(cfg.dest_ip[31:16]) + 20'(cfg.dest_ip[15:0])
                    + 20'(cfg.source_port) + 20'(cfg.dest_port)
                    + 20'(cfg.window_size) + 20'(cfg.max_segment);

        tcp_sum   = 21'(tcp_cfg_sum_reg) + 21'(head_req.part_sum);
        tcp_fold1 = 17'(tcp_sum[15:0]) + 17'(tcp_sum[20:16]);
        tcp_fold2 = tcp_fold1[15:0] + 16'(tcp_fold1[16]);
    end

    always_ff @(posedge clk)
    begin
        ip_csum_reg     <= ~ip_fold2;
        tcp_cfg_sum_reg <= tcp_cfg_sum;
    end

    assign advance = !out_valid_reg || m_axis_tready;
    assign emit    = active_reg && advance;
    // next request loads while the last word of the current one goes out
    assign load    = head_valid && (!active_reg || (emit && idx_reg == LAST_INDEX));
    assign pop     = load;

    always_comb
    begin
        case (idx_reg)
            6'd0:    word = cfg.dest_mac[47:32];
            6'd1:    word = cfg.dest_mac[31:16];
            6'd2:    word = cfg.dest_mac[15:0];
            6'd3:    word = cfg.source_mac[47:32];
            6'd4:    word = cfg.source_mac[31:16];
            6'd5:    word = cfg.source_mac[15:0];
            6'd6:    word = ETHERTYPE_IPV4;
            6'd7:    word = IP_VER_IHL_TOS;
            6'd8:    word = IP_TOTAL_LEN;
            6'd9:    word = IP_IDENT;
            6'd10:   word = IP_FLAGS_DF;
            6'd11:   word = IP_TTL_PROTO;
            6'd12:   word = ip_csum_reg;
            6'd13:   word = cfg.ip_src_addr[31:16];
            6'd14:   word = cfg.ip_src_addr[15:0];
            6'd15:   word = cfg.dest_ip[31:16];
            6'd16:   word = cfg.dest_ip[15:0];
            6'd17:   word = cfg.source_port;
            6'd18:   word = cfg.dest_port;
            6'd19:   word = seq_reg[31:16];
            6'd20:   word = seq_reg[15:0];
            6'd21:   word = ack_reg[31:16];
            6'd22:   word = ack_reg[15:0];
            6'd23:   word = TCP_OFF_FLAGS;
            6'd24:   word = cfg.window_size;
            6'd25:   word = tcp_csum_reg;
            6'd26:   word = 16'h0000;
            6'd27:   word = OPT_MSS_HDR;
            6'd28:   word = cfg.max_segment;
            6'd29:   word = OPT_SACK_OK;
            6'd30:   word = OPT_TS_HDR;
            6'd31:   word = TS_VALUE_HI;
            6'd32:   word = TS_VALUE_LO;
            6'd33:   word = 16'h0000;
            6'd34:   word = 16'h0000;
            6'd35:   word = OPT_NOP_WS;
            6'd36:   word = OPT_WS_SHIFT;
            default: word = 16'h0000;
        endcase
    end

    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (idx_reg == LAST_INDEX)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (load)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seq_reg      <= head_req.seq;
            ack_reg      <= head_req.ack;
            tcp_csum_reg <= ~tcp_fold2;
        end
        if (emit)
        begin
            out_word_reg  <= word;
            out_index_reg <= idx_reg;
            out_last_reg  <= (idx_reg == LAST_INDEX);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_index_reg, out_word_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // the last flag only ever sits on the final word index
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_index_reg == LAST_INDEX))
        else $error("tlast on a word other than the final one");

    // inside a frame the next word follows right after a taken word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && m_axis_tready && !out_last_reg) |=> out_valid_reg)
        else $error("gap inside a frame");

    // a new request is only taken from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> head_valid)
        else $error("pop from an empty queue");

    // a frame does not restart while words of the previous one remain
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && active_reg) |-> (idx_reg == LAST_INDEX))
        else $error("request loaded in the middle of a frame");
`endif

endmodule
